// ----- hdl/bqc_pkg.sv -----
// shared types and constants for the biquad cascade filter
// no dependencies; imported by every module of the block
`default_nettype none

package bqc_pkg;

	// coefficients per section, in table order
	localparam int NUM_COEFFS  = 5;
	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// input command codes
	localparam logic [1:0] CMD_FILTER = 2'd0;
	localparam logic [1:0] CMD_WRITE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// coefficient select codes, also the operand order of one section
	localparam logic [2:0] COEF_B0 = 3'd0;
	localparam logic [2:0] COEF_B1 = 3'd1;
	localparam logic [2:0] COEF_B2 = 3'd2;
	localparam logic [2:0] COEF_A1 = 3'd3;
	localparam logic [2:0] COEF_A2 = 3'd4;

	// register word index of active_sections
	localparam logic CFG_ACTIVE_SECTIONS = 1'b0;

	// classified request kinds carried through the queue
	typedef enum logic [1:0] {
		OP_FILTER,
		OP_WRITE,
		OP_CLEAR,
		OP_NONE
	} op_kind_t;

	// back-end status seen by the top level
	typedef struct packed {
		logic busy;
		logic pipe_active;
	} bqc_status_t;

endpackage

`default_nettype wire

// ----- hdl/bqc_front.sv -----
// front end: decodes input requests and pushes them into the queue
// depends on bqc_pkg
`default_nettype none

module bqc_front #(
	parameter int MAX_SECTIONS = 8,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEFF_WIDTH  = 18,
	localparam int CADDR_W     = $clog2(bqc_pkg::NUM_COEFFS * MAX_SECTIONS)
) (
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     command,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  wire logic [2:0]                     section_index,
	input  wire logic [2:0]                     coeff_select,
	input  wire logic signed [COEFF_WIDTH-1:0]  coeff_value,
	input  wire logic                           q_full,
	output logic                                q_push,
	output bqc_pkg::op_kind_t                   op_kind,
	output logic signed [SAMPLE_WIDTH-1:0]      op_sample,
	output logic [CADDR_W-1:0]                  op_caddr,
	output logic signed [COEFF_WIDTH-1:0]       op_cvalue
);
	import bqc_pkg::*;

	logic       addr_ok;
	logic [5:0] lin_addr;

	// out-of-range writes are dropped here
	assign addr_ok = ({29'd0, section_index} < 32'(MAX_SECTIONS)) &&
		(coeff_select < 3'(NUM_COEFFS));

	// section * 5 + select
	assign lin_addr = {1'b0, section_index, 2'b00} + 6'(section_index) + 6'(coeff_select);

	always_comb begin
		case (command)
			CMD_FILTER: op_kind = OP_FILTER;
			CMD_WRITE: begin
				op_kind = addr_ok ? OP_WRITE : OP_NONE;
			end
			CMD_CLEAR: op_kind = OP_CLEAR;
			default: op_kind = OP_NONE;
		endcase
	end

	assign op_sample = sample_in;
	assign op_caddr  = CADDR_W'(lin_addr);
	assign op_cvalue = coeff_value;

	assign in_ready = !q_full;
	// requests with no effect are accepted and dropped
	assign q_push   = in_valid && !q_full && (op_kind != OP_NONE);

endmodule

`default_nettype wire

// ----- hdl/bqc_queue.sv -----
// short fifo between front end and back end
// depends on bqc_pkg for its depth
`default_nettype none

module bqc_queue #(
	parameter int W = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);
	import bqc_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;

	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bqc_back.sv -----
// back end: coefficient memory, history taps, shared multiply-accumulate
// sequencer and output register; depends on bqc_pkg
`default_nettype none

module bqc_back #(
	parameter int MAX_SECTIONS = 8,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEFF_WIDTH  = 18,
	localparam int CADDR_W     = $clog2(bqc_pkg::NUM_COEFFS * MAX_SECTIONS)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic [3:0]                     active_sections,
	input  wire logic                           q_valid,
	output logic                                q_ready,
	input  wire bqc_pkg::op_kind_t              q_kind,
	input  wire logic signed [SAMPLE_WIDTH-1:0] q_sample,
	input  wire logic [CADDR_W-1:0]             q_caddr,
	input  wire logic signed [COEFF_WIDTH-1:0]  q_cvalue,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output logic                                clipped,
	output bqc_pkg::bqc_status_t                status
);
	import bqc_pkg::*;

	localparam int FRAC      = COEFF_WIDTH - 2;
	localparam int PROD_W    = SAMPLE_WIDTH + COEFF_WIDTH;
	localparam int ACC_W     = (PROD_W + 3 > 64) ? 64 : PROD_W + 3;
	localparam int SH_W      = ACC_W - FRAC;
	localparam int COEF_DEPTH = NUM_COEFFS * MAX_SECTIONS;
	localparam int SEC_W     = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int SEC_CNT_W = $clog2(MAX_SECTIONS + 1);

	localparam logic signed [ACC_W-1:0]        RND  = ACC_W'(1) << (FRAC - 1);
	localparam logic signed [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                         state_q;
	logic [2:0]                     j_q;
	logic [CADDR_W-1:0]             addr_q;
	logic [SEC_CNT_W-1:0]           sec_q;
	logic [SEC_CNT_W-1:0]           n_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic                           clipped_q;

	logic signed [COEFF_WIDTH-1:0]  coef_mem [COEF_DEPTH];
	logic [COEF_DEPTH-1:0]          coef_vld_q;

	logic signed [COEFF_WIDTH-1:0]  coef_rd_s1;
	logic                           coef_ok_s1;
	logic                           vld_s1;
	logic [2:0]                     j_s1;
	logic signed [PROD_W-1:0]       prod_s2;
	logic                           neg_s2;
	logic                           vld_s2;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic                           clip_q;

	logic signed [SAMPLE_WIDTH-1:0] in1_q  [MAX_SECTIONS];
	logic signed [SAMPLE_WIDTH-1:0] in2_q  [MAX_SECTIONS];
	logic signed [SAMPLE_WIDTH-1:0] out1_q [MAX_SECTIONS];
	logic signed [SAMPLE_WIDTH-1:0] out2_q [MAX_SECTIONS];

	logic [SEC_CNT_W-1:0]           n_clamp;
	logic [SEC_CNT_W-1:0]           sec_next;
	logic [SEC_W-1:0]               sidx;
	logic                           start;
	logic                           pop;
	logic                           wr_en;
	logic                           clr_en;
	logic                           issue;
	logic                           pipe_empty;
	logic                           finish;
	logic                           out_free;
	logic signed [SAMPLE_WIDTH-1:0] operand;
	logic signed [COEFF_WIDTH-1:0]  coef_eff;
	logic signed [ACC_W-1:0]        prod_ext;
	logic [SH_W-1:0]                sh;
	logic [SH_W-SAMPLE_WIDTH:0]     sh_top;
	logic                           sat;
	logic signed [SAMPLE_WIDTH-1:0] y;

	// control
	assign n_clamp = ({1'b0, active_sections} > 5'(MAX_SECTIONS)) ?
		SEC_CNT_W'(MAX_SECTIONS) : SEC_CNT_W'(active_sections);
	assign sec_next   = sec_q + 1'b1;
	assign sidx       = sec_q[SEC_W-1:0];
	assign q_ready    = (state_q == ST_IDLE);
	assign pop        = q_valid && q_ready;
	assign start      = pop && (q_kind == OP_FILTER);
	assign wr_en      = pop && (q_kind == OP_WRITE);
	assign clr_en     = pop && (q_kind == OP_CLEAR);
	assign issue      = (state_q == ST_ISSUE);
	assign pipe_empty = !vld_s1 && !vld_s2;
	assign finish     = (state_q == ST_DRAIN) && pipe_empty;
	assign out_free   = !out_valid_q || out_ready;

	// operand for the coefficient read in the cycle before
	always_comb begin
		case (j_s1)
			COEF_B0: operand = x_q;
			COEF_B1: operand = in1_q[sidx];
			COEF_B2: operand = in2_q[sidx];
			COEF_A1: operand = out1_q[sidx];
			COEF_A2: operand = out2_q[sidx];
			default: operand = '0;
		endcase
	end

	// never-written coefficients read as zero
	assign coef_eff = coef_ok_s1 ? coef_rd_s1 : '0;
	assign prod_ext = ACC_W'(prod_s2);

	// round constant is preloaded in the accumulator, so only shift and clamp here
	assign sh     = acc_q[ACC_W-1:FRAC];
	assign sh_top = sh[SH_W-1:SAMPLE_WIDTH-1];
	assign sat    = !((&sh_top) || !(|sh_top));
	assign y      = sat ? (sh[SH_W-1] ? SMIN : SMAX) : sh[SAMPLE_WIDTH-1:0];

	// coefficient memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			coef_mem[q_caddr] <= q_cvalue;
		end
		if (issue) begin
			coef_rd_s1 <= coef_mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
		end else if (wr_en) begin
			coef_vld_q[q_caddr] <= 1'b1;
		end
	end

	// multiply-accumulate pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			j_s1       <= j_q;
			coef_ok_s1 <= coef_vld_q[addr_q];
		end
		prod_s2 <= coef_eff * operand;
		neg_s2  <= (j_s1 == COEF_A1) || (j_s1 == COEF_A2);
		if (start || finish) begin
			acc_q <= RND;
		end else if (vld_s2) begin
			acc_q <= neg_s2 ? acc_q - prod_ext : acc_q + prod_ext;
		end
		if (start) begin
			x_q    <= q_sample;
			clip_q <= 1'b0;
		end else if (finish) begin
			x_q    <= y;
			clip_q <= clip_q | sat;
		end
	end

	// history taps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				in1_q[i]  <= '0;
				in2_q[i]  <= '0;
				out1_q[i] <= '0;
				out2_q[i] <= '0;
			end
		end else if (clr_en) begin
			for (int i = 0; i < MAX_SECTIONS; i++) begin
				in1_q[i]  <= '0;
				in2_q[i]  <= '0;
				out1_q[i] <= '0;
				out2_q[i] <= '0;
			end
		end else if (finish) begin
			in1_q[sidx]  <= x_q;
			in2_q[sidx]  <= in1_q[sidx];
			out1_q[sidx] <= y;
			out2_q[sidx] <= out1_q[sidx];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			j_q          <= '0;
			addr_q       <= '0;
			sec_q        <= '0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
			clipped_q    <= 1'b0;
		end else begin
			// in ST_DONE the output register is handled by the state itself
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q     <= n_clamp;
						sec_q   <= '0;
						addr_q  <= '0;
						j_q     <= '0;
						state_q <= (n_clamp == '0) ? ST_DONE : ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					addr_q <= addr_q + 1'b1;
					if (j_q == 3'(NUM_COEFFS - 1)) begin
						j_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						sec_q   <= sec_next;
						state_q <= (sec_next == n_q) ? ST_DONE : ST_ISSUE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						sample_out_q <= x_q;
						clipped_q    <= clip_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign sample_out         = sample_out_q;
	assign clipped            = clipped_q;
	assign status.busy        = (state_q != ST_IDLE);
	assign status.pipe_active = !pipe_empty;

endmodule

`default_nettype wire

// ----- hdl/biquad_cascade_filter.sv -----
// top level of the cascaded direct form I biquad filter
// depends on bqc_pkg, bqc_front, bqc_queue and bqc_back
//
// Usage:
// - input channel (in_valid/in_ready) carries one request: command 0 filters
//   sample_in, command 1 writes coeff_value to coefficient coeff_select of
//   section section_index, command 2 clears all section histories, command 3
//   is dropped; only command 0 gives a result
// - output channel (out_valid/out_ready) carries sample_out and clipped
// - active_sections is written over the APB port (byte address 0) while the
//   block is idle; values above MAX_SECTIONS act as MAX_SECTIONS
// - one shared multiplier does the five products of each section in turn:
//   each section issues its five products, then drains the multiply
//   pipeline before the next section starts; a filter request holds the
//   back end until its result is in the output register
// - coefficient writes and clears are done as the back end takes them, and it stays idle
// - a two-entry queue sits between the decode front end and the back end, so
//   requests are still accepted while a result waits in the output register
// - when the receiver stalls, the result holds and the back end waits;
//   the queue fills and in_ready drops
// - reset clears the coefficient table, all histories, the queue and
//   active_sections (pass-through)
`default_nettype none

module biquad_cascade_filter #(
	parameter int MAX_SECTIONS = 8,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEFF_WIDTH  = 18
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// APB configuration port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [2:0]                     paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// request channel
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [1:0]                     command,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  wire logic [2:0]                     section_index,
	input  wire logic [2:0]                     coeff_select,
	input  wire logic signed [COEFF_WIDTH-1:0]  coeff_value,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output logic                                clipped
);
	import bqc_pkg::*;

	localparam int CADDR_W = $clog2(NUM_COEFFS * MAX_SECTIONS);
	// queue word: kind, sample, coefficient address, coefficient value
	localparam int Q_W     = 2 + SAMPLE_WIDTH + CADDR_W + COEFF_WIDTH;

	logic [3:0]                     active_sections_q;
	logic                           apb_wr;

	logic                           q_full;
	logic                           q_push;
	op_kind_t                       op_kind;
	logic signed [SAMPLE_WIDTH-1:0] op_sample;
	logic [CADDR_W-1:0]             op_caddr;
	logic signed [COEFF_WIDTH-1:0]  op_cvalue;
	logic [Q_W-1:0]                 q_in;
	logic [Q_W-1:0]                 q_out;
	logic                           q_valid;
	logic                           q_ready;
	op_kind_t                       q_kind;
	bqc_status_t                    back_status;

	// register write on the access phase; word index sits in paddr[2]
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_sections_q <= '0;
		end else if (apb_wr && (paddr[2] == CFG_ACTIVE_SECTIONS)) begin
			active_sections_q <= pwdata[3:0];
		end
	end

	// unmapped words read as zero
	assign prdata = (paddr[2] == CFG_ACTIVE_SECTIONS) ? {28'd0, active_sections_q} : '0;

	// front end: decode and drop requests with no effect
	bqc_front #(
		.MAX_SECTIONS(MAX_SECTIONS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.sample_in    (sample_in),
		.section_index(section_index),
		.coeff_select (coeff_select),
		.coeff_value  (coeff_value),
		.q_full       (q_full),
		.q_push       (q_push),
		.op_kind      (op_kind),
		.op_sample    (op_sample),
		.op_caddr     (op_caddr),
		.op_cvalue    (op_cvalue)
	);

	assign q_in = {op_kind, op_sample, op_caddr, op_cvalue};

	// decoupling queue
	bqc_queue #(
		.W(Q_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop_valid(q_valid),
		.pop_ready(q_ready),
		.pop_data (q_out)
	);

	assign q_kind = op_kind_t'(q_out[Q_W-1 -: 2]);

	// back end: sections run one after another on a shared multiplier
	bqc_back #(
		.MAX_SECTIONS(MAX_SECTIONS),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEFF_WIDTH (COEFF_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.active_sections(active_sections_q),
		.q_valid        (q_valid),
		.q_ready        (q_ready),
		.q_kind         (q_kind),
		.q_sample       (q_out[CADDR_W+COEFF_WIDTH +: SAMPLE_WIDTH]),
		.q_caddr        (q_out[COEFF_WIDTH +: CADDR_W]),
		.q_cvalue       (q_out[COEFF_WIDTH-1:0]),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_out     (sample_out),
		.clipped        (clipped),
		.status         (back_status)
	);

`ifndef SYNTHESIS
	// an accepted filter request is waiting in the queue on the next cycle
	a_filter_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (command == CMD_FILTER)) |=> q_valid)
		else $error("filter request lost between front end and queue");

	// the back end never takes a new request while products are in flight
	a_no_pop_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.pipe_active |-> !(q_valid && q_ready))
		else $error("queue popped while the multiply pipeline is active");

	// a filter request taken from the queue keeps the back end busy
	a_busy_after_filter: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready && (q_kind == OP_FILTER)) |=> back_status.busy)
		else $error("back end idle right after taking a filter request");
`endif

endmodule

`default_nettype wire
